/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FNFCA_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fnfca assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FNFCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fnfca assertion failed");

`endif

/* sv/fnfca_pkg.sv */
package fnfca_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned EntryW     = 28;
  localparam int unsigned ClusterW   = 12;
  localparam int unsigned CountW     = 12;
  localparam int unsigned BitW       = $clog2(ClusterW);

  // largest scan length: clusters that exist in the table and fit in 12 bits
  localparam int unsigned MaxClustersInt =
      ((TableDepth - 2) < 4094) ? (TableDepth - 2) : 4094;

  localparam logic [ClusterW-1:0] FirstCluster = ClusterW'(2);
  localparam logic [ClusterW-1:0] HintReset    = ClusterW'(3);
  localparam logic [ClusterW-1:0] MaxClusters  = ClusterW'(MaxClustersInt);

  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_ALLOC  = 2'd2,
    FUNC_REWIND = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_SCAN,
    ST_DONE
  } fsm_e;

  typedef struct packed {
    logic [EntryW-1:0]   read_value;
    logic [ClusterW-1:0] free_cluster;
    logic                found;
  } rsp_t;

endpackage

/* sv/fnfca_cfg_if.sv */
interface fnfca_cfg_if import fnfca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] cluster_count;

  modport source (output valid, output cluster_count, input ready);
  modport sink (input valid, input cluster_count, output ready);
endinterface

/* sv/fnfca_req_if.sv */
interface fnfca_req_if import fnfca_pkg::*; ();
  logic                valid;
  logic                ready;
  func_e               func;
  logic [ClusterW-1:0] cluster_index;
  logic [EntryW-1:0]   entry_value;

  modport source (output valid, output func, output cluster_index, output entry_value,
                  input ready);
  modport sink (input valid, input func, input cluster_index, input entry_value,
                output ready);
endinterface

/* sv/fnfca_rsp_if.sv */
interface fnfca_rsp_if import fnfca_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [EntryW-1:0]   read_value;
  logic [ClusterW-1:0] free_cluster;
  logic                found;

  modport source (output valid, output read_value, output free_cluster, output found,
                  input ready);
  modport sink (input valid, input read_value, input free_cluster, input found,
                output ready);
endinterface

/* sv/fat_next_fit_cluster_allocator_unit.sv */
// FAT32 next-fit cluster allocator.
// Channels: cfg_i writes cluster_count (always ready). req_i carries one
// operation per transaction (read entry, write entry, allocate, rewind hint);
// rsp_o returns exactly one result transaction per request, in order.
// Path from accept to result: read via ST_READ then ST_DONE, write and
// rewind straight to ST_DONE. Allocate (n = effective cluster count): a
// shared restoring subtract unit in ST_DIV reduces the hint modulo n to a
// scan start, then ST_SCAN reads one table entry per cycle through the
// single read port of the 4096 x 28 table, with registered read data.
// One request is in flight at a time; req_i.ready is low until its result
// is in the output register, so a new request may enter while that result
// still waits on rsp_o.
// Reset: the table is swept to zero, one entry per cycle; no request is
// taken during the sweep, config writes are. Hint resets to 3.
// Receiver stall: the result holds in rsp_o until taken; a finished
// operation waits in its done state while the output register is full.
`include "assert_macros.svh"

module fat_next_fit_cluster_allocator_unit import fnfca_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  fnfca_cfg_if.sink   cfg_i,
  fnfca_req_if.sink   req_i,
  fnfca_rsp_if.source rsp_o
);

  // allocation table, no reset: cleared by the sweep after reset
  logic [EntryW-1:0] mem [TableDepth];

  fsm_e                state_q, state_d;
  logic [AddrW-1:0]    clr_addr_q, clr_addr_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [ClusterW-1:0] hint_q, hint_d;
  logic [ClusterW-1:0] n_q, n_d;        // effective count of current allocate
  logic [ClusterW-1:0] div_q, div_d;    // hint - 2, dividend
  logic [ClusterW-1:0] rem_q, rem_d;
  logic [BitW-1:0]     bit_q, bit_d;
  logic [ClusterW-1:0] pos_q, pos_d;    // next scan offset to issue
  logic [ClusterW-1:0] left_q, left_d;  // reads still to issue
  logic                rd_vld_q, rd_vld_d;
  logic [ClusterW-1:0] rd_pos_q, rd_pos_d;
  logic [EntryW-1:0]   mem_rdata_q;
  rsp_t                pend_q, pend_d;
  rsp_t                rsp_q, rsp_d;
  logic                rsp_valid_q, rsp_valid_d;

  logic                mem_we, mem_re;
  logic [AddrW-1:0]    mem_waddr, mem_raddr;
  logic [EntryW-1:0]   mem_wdata;

  logic [ClusterW:0]   trial;
  logic [ClusterW-1:0] rem_next;
  logic [ClusterW-1:0] eff_count;
  logic                hit;
  logic                out_free;

  assign cfg_i.ready        = 1'b1;
  assign req_i.ready        = (state_q == ST_IDLE);
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.read_value   = rsp_q.read_value;
  assign rsp_o.free_cluster = rsp_q.free_cluster;
  assign rsp_o.found        = rsp_q.found;

  // shared unit: one restoring step of (hint - 2) mod n
  assign trial    = {rem_q, div_q[bit_q]};
  assign rem_next = (trial >= {1'b0, n_q}) ? ClusterW'(trial - {1'b0, n_q})
                                           : trial[ClusterW-1:0];

  assign eff_count = (count_q > MaxClusters) ? MaxClusters : count_q;
  assign hit       = rd_vld_q && (mem_rdata_q == '0);
  assign out_free  = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    count_d     = count_q;
    hint_d      = hint_q;
    n_d         = n_q;
    div_d       = div_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    pos_d       = pos_q;
    left_d      = left_q;
    rd_vld_d    = 1'b0;
    rd_pos_d    = rd_pos_q;
    pend_d      = pend_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    mem_we      = 1'b0;
    mem_waddr   = clr_addr_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = AddrW'(req_i.cluster_index);

    if (cfg_i.valid) begin
      count_d = cfg_i.cluster_count;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        clr_addr_d = clr_addr_q + AddrW'(1);
        if (clr_addr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          pend_d = '0;
          unique case (req_i.func)
            FUNC_READ: begin
              mem_re  = 1'b1;
              state_d = ST_READ;
            end
            FUNC_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = AddrW'(req_i.cluster_index);
              mem_wdata = req_i.entry_value;
              state_d   = ST_DONE;
            end
            FUNC_ALLOC: begin
              if (eff_count == '0) begin
                state_d = ST_DONE;
              end else begin
                n_d     = eff_count;
                div_d   = hint_q - FirstCluster;
                rem_d   = '0;
                bit_d   = BitW'(ClusterW - 1);
                state_d = ST_DIV;
              end
            end
            FUNC_REWIND: begin
              hint_d  = FirstCluster;
              state_d = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        pend_d.read_value = mem_rdata_q;
        state_d           = ST_DONE;
      end
      ST_DIV: begin
        rem_d = rem_next;
        bit_d = bit_q - BitW'(1);
        if (bit_q == '0) begin
          pos_d   = rem_next;
          left_d  = n_q;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          pend_d.free_cluster = FirstCluster + rd_pos_q;
          pend_d.found        = 1'b1;
          hint_d  = (rd_pos_q == n_q - ClusterW'(1)) ? FirstCluster
                                                     : FirstCluster + rd_pos_q + ClusterW'(1);
          state_d = ST_DONE;
        end else if (left_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = AddrW'(FirstCluster + pos_q);
          rd_vld_d  = 1'b1;
          rd_pos_d  = pos_q;
          pos_d     = (pos_q == n_q - ClusterW'(1)) ? '0 : pos_q + ClusterW'(1);
          left_d    = left_q - ClusterW'(1);
        end else begin
          // every cluster checked, none free
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_d       = pend_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      count_q     <= '0;
      hint_q      <= HintReset;
      rd_vld_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      count_q     <= count_d;
      hint_q      <= hint_d;
      rd_vld_q    <= rd_vld_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    div_q    <= div_d;
    rem_q    <= rem_d;
    bit_q    <= bit_d;
    pos_q    <= pos_d;
    left_q   <= left_d;
    rd_pos_q <= rd_pos_d;
    pend_q   <= pend_d;
    rsp_q    <= rsp_d;
  end

  `FNFCA_ASSERT(a_hint_range, 1'b1, hint_q >= FirstCluster)
  `FNFCA_ASSERT(a_found_cluster, rsp_o.valid && rsp_o.found, (rsp_o.free_cluster >= FirstCluster) && (rsp_o.read_value == '0))
  `FNFCA_ASSERT(a_scan_pos, state_q == ST_SCAN, (pos_q < n_q) && (n_q != '0))
  `FNFCA_ASSERT_NEXT(a_busy_after_accept, req_i.valid && req_i.ready, !req_i.ready)
  `FNFCA_ASSERT_NEXT(a_clear_ends, (state_q == ST_CLEAR) && (clr_addr_q == '1), state_q == ST_IDLE)

endmodule
